FILE: design/masked_signature_scan_core_assert.svh
// Assertion macros shared by the scan core checkers.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef MASKED_SIGNATURE_SCAN_CORE_ASSERT_SVH
`define MASKED_SIGNATURE_SCAN_CORE_ASSERT_SVH

// cond must hold at every clock edge out of reset
`define MSSCAN_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante at one edge requires cons at the next edge
`define MSSCAN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/msscan_pkg.sv
// Shared types and constants for the masked signature scan core.
// No dependencies; used by every module of the block.
package msscan_pkg;

  localparam int MAX_PATTERN_BYTES_DEF = 16;
  localparam int POSITION_BITS_DEF     = 32;

  localparam int PATTERN_SLOTS = 16;   // bytes held by the pattern/mask registers
  localparam int SLOT_W        = 4;
  localparam int LEN_W         = 5;
  localparam int ADDR_W        = 32;
  localparam int OFFSET_W      = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH     = 3'd0,
    REG_PATTERN_BYTES_LOW  = 3'd1,
    REG_PATTERN_BYTES_HIGH = 3'd2,
    REG_MASK_BYTES_LOW     = 3'd3,
    REG_MASK_BYTES_HIGH    = 3'd4,
    REG_MATCH_OFFSET       = 3'd5,
    REG_REGION_BASE        = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [LEN_W-1:0]                  eff_len;   // already clamped to 1..max
    logic [PATTERN_SLOTS-1:0][7:0]     pattern;
    logic [PATTERN_SLOTS-1:0][7:0]     mask;
    logic signed [OFFSET_W-1:0]        offset;
    logic [ADDR_W-1:0]                 base;
  } msscan_cfg_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

FILE: design/masked_signature_scan_core.sv
// Masked signature scan core: one byte item per cycle unless stalled, results
// pass a compare stage register and then an output register. Throughput is
// one item per cycle while the output is not stalled, set by the cell row
// that compares every lag in parallel while the window shifts. Synchronous
// active-low reset clears window, position, match flag and pipeline valids;
// configuration resets to pattern length 1 and all other registers zero.
module masked_signature_scan_core import msscan_pkg::*; #(
  parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
  parameter int POSITION_BITS     = POSITION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_end_of_region,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_found,
  output logic [ADDR_W-1:0]     out_match_address,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  msscan_cfg_t cfg;

  msscan_cfg #(.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic                     acc;
  logic                     hit;
  logic                     res_fire;
  logic                     adv;
  cell_ctrl_t               ctrl;
  logic [MAX_PATTERN_BYTES:0][7:0] chain;
  logic [MAX_PATTERN_BYTES-1:0]    ok_vec;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic                     matched_r, matched_nxt;
  logic [ADDR_W-1:0]        pos_lo;
  logic [ADDR_W-1:0]        start;

  logic                     s1_valid_r;
  logic                     s1_found_r;
  logic [ADDR_W-1:0]        s1_start_r;
  logic                     out_valid_r;
  logic                     out_found_r;
  logic [ADDR_W-1:0]        out_addr_r;
  logic [ADDR_W-1:0]        addr;

  assign acc = in_valid && in_ready;

  // cell k sees the byte at lag k; lag 0 is the incoming byte
  assign chain[0] = in_data_byte;

  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    msscan_cell #(.LAG(k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .byte_in  (chain[k]),
      .eff_len  (cfg.eff_len),
      .pattern  (cfg.pattern),
      .mask     (cfg.mask),
      .byte_out (chain[k+1]),
      .ok       (ok_vec[k])
    );
  end

  assign hit = !matched_r && (&ok_vec) &&
               (pos_r >= POSITION_BITS'(cfg.eff_len) - POSITION_BITS'(1));
  assign res_fire = acc && !matched_r && (hit || in_end_of_region);

  assign ctrl.clear = acc && in_end_of_region;
  assign ctrl.shift = acc && !in_end_of_region && !matched_r && !hit;

  always_comb begin
    pos_nxt     = pos_r;
    matched_nxt = matched_r;
    if (acc) begin
      if (in_end_of_region) begin
        pos_nxt     = '0;
        matched_nxt = 1'b0;
      end else if (hit) begin
        matched_nxt = 1'b1;
      end else if (!matched_r && pos_r != '1) begin
        pos_nxt = pos_r + POSITION_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      matched_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      matched_r <= matched_nxt;
    end
  end

  // only the low address bits matter for the modulo-2^32 sum
  if (POSITION_BITS >= ADDR_W) begin : g_pos_trunc
    assign pos_lo = pos_r[ADDR_W-1:0];
  end else begin : g_pos_ext
    assign pos_lo = {{(ADDR_W-POSITION_BITS){1'b0}}, pos_r};
  end

  assign start = pos_lo + ADDR_W'(1) - ADDR_W'(cfg.eff_len);

  // two-stage pipe with a shared stall
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= res_fire;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_found_r <= hit;
      s1_start_r <= start;
    end
    if (adv) begin
      out_found_r <= s1_found_r;
      out_addr_r  <= addr;
    end
  end

  assign addr = s1_found_r ?
                cfg.base + s1_start_r + ADDR_W'(cfg.offset) : '0;

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_match_address = out_addr_r;

endmodule

FILE: design/msscan_cfg.sv
// Configuration register file of the scan core.
// Depends on msscan_pkg.
module msscan_cfg import msscan_pkg::*; #(
  parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output msscan_cfg_t           cfg
);

  logic [LEN_W-1:0]      len_r;
  logic [CFG_DATA_W-1:0] pat_lo_r, pat_hi_r, msk_lo_r, msk_hi_r;
  logic [OFFSET_W-1:0]   off_r;
  logic [ADDR_W-1:0]     base_r;
  logic [LEN_W-1:0]      len_wr;

  assign cfg_ready = 1'b1;

  // zero reads as one, anything past the window as the window size
  always_comb begin
    len_wr = cfg_data[LEN_W-1:0];
    if (len_wr == '0) begin
      len_wr = LEN_W'(1);
    end else if (len_wr > LEN_W'(MAX_PATTERN_BYTES)) begin
      len_wr = LEN_W'(MAX_PATTERN_BYTES);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= LEN_W'(1);
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      msk_lo_r <= '0;
      msk_hi_r <= '0;
      off_r    <= '0;
      base_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LENGTH:     len_r    <= len_wr;
        REG_PATTERN_BYTES_LOW:  pat_lo_r <= cfg_data;
        REG_PATTERN_BYTES_HIGH: pat_hi_r <= cfg_data;
        REG_MASK_BYTES_LOW:     msk_lo_r <= cfg_data;
        REG_MASK_BYTES_HIGH:    msk_hi_r <= cfg_data;
        REG_MATCH_OFFSET:       off_r    <= cfg_data[OFFSET_W-1:0];
        REG_REGION_BASE:        base_r   <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.eff_len = len_r;
  assign cfg.pattern = {pat_hi_r, pat_lo_r};
  assign cfg.mask    = {msk_hi_r, msk_lo_r};
  assign cfg.offset  = off_r;
  assign cfg.base    = base_r;

endmodule

FILE: design/msscan_cell.sv
// One window cell: compares the byte at its lag with the matching pattern byte
// and passes the byte on to the next lag. Depends on msscan_pkg.
module msscan_cell import msscan_pkg::*; #(
  parameter int LAG = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cell_ctrl_t                    ctrl,
  input  logic [7:0]                    byte_in,
  input  logic [LEN_W-1:0]              eff_len,
  input  logic [PATTERN_SLOTS-1:0][7:0] pattern,
  input  logic [PATTERN_SLOTS-1:0][7:0] mask,
  output logic [7:0]                    byte_out,
  output logic                          ok
);

  logic [7:0]       byte_r;
  logic [LEN_W-1:0] slot;
  logic             unused_lag;

  // pattern byte j sits at lag len-1-j
  assign slot       = eff_len - LEN_W'(LAG) - LEN_W'(1);
  assign unused_lag = LEN_W'(LAG) >= eff_len;
  assign ok = unused_lag ||
              ((byte_in & mask[slot[SLOT_W-1:0]]) == pattern[slot[SLOT_W-1:0]]);

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      byte_r <= '0;
    end else if (ctrl.shift) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;

endmodule

FILE: design/msscan_checker.sv
// Port-level checks for the masked signature scan core, bound to the top.
// Depends on msscan_pkg and masked_signature_scan_core_assert.svh.
`include "masked_signature_scan_core_assert.svh"

module msscan_checker import msscan_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_found,
  input logic [ADDR_W-1:0] out_match_address
);

  // a stalled result must hold
  `MSSCAN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_found) && $stable(out_match_address), "result changed while stalled")

  // not-found items carry a zero address
  `MSSCAN_ASSERT(a_notfound_zero, !out_valid || out_found || out_match_address == '0, "not-found item with nonzero address")

  // input stalls only behind a blocked result
  `MSSCAN_ASSERT(a_stall_cause, in_ready || (out_valid && !out_ready), "input stalled without output backpressure")

endmodule

bind masked_signature_scan_core msscan_checker u_msscan_checker (.*);
